// ===== rtl/core/triangle_tangent_binormal_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tangent/binormal block
// Simulation builds expand them into concurrent assertions; synthesis builds
// see empty bodies.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BINORMAL_TOP_MACROS_SVH
`define TRIANGLE_TANGENT_BINORMAL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define TTB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define TTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define TTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg
// Types, codes and the microcode table shared by the tangent/binormal block.
// ----------------------------------------------------------------------------
package ttb_pkg;

  // Data widths.
  localparam int DW        = 32;
  localparam int PW        = 2 * DW;
  localparam int IN_W      = 5 * DW;
  localparam int OUT_W     = 6 * DW;
  localparam int NUM_LANES = 6;
  localparam int QBITS     = DW + 1;

  localparam logic [DW-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] SAT_MIN = 32'h8000_0000;

  // Multiplier operand A file: position deltas plus du1 and dv1.
  localparam int A_DEPTH = 8;
  localparam logic [2:0] A_DP1X = 3'd0;
  localparam logic [2:0] A_DP1Y = 3'd1;
  localparam logic [2:0] A_DP1Z = 3'd2;
  localparam logic [2:0] A_DP2X = 3'd3;
  localparam logic [2:0] A_DP2Y = 3'd4;
  localparam logic [2:0] A_DP2Z = 3'd5;
  localparam logic [2:0] A_DU1  = 3'd6;
  localparam logic [2:0] A_DV1  = 3'd7;

  // Multiplier operand B file: texture coordinate deltas.
  localparam int B_DEPTH = 4;
  localparam logic [1:0] B_DU1 = 2'd0;
  localparam logic [1:0] B_DV1 = 2'd1;
  localparam logic [1:0] B_DU2 = 2'd2;
  localparam logic [1:0] B_DV2 = 2'd3;

  // Accumulator registers.
  localparam int NUM_ACC = 7;
  localparam logic [2:0] ACC_DET = 3'd0;
  localparam logic [2:0] ACC_T0  = 3'd1;
  localparam logic [2:0] ACC_T1  = 3'd2;
  localparam logic [2:0] ACC_T2  = 3'd3;
  localparam logic [2:0] ACC_B0  = 3'd4;
  localparam logic [2:0] ACC_B1  = 3'd5;
  localparam logic [2:0] ACC_B2  = 3'd6;

  // Accumulator operations on the previous product.
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_SUB  = 2'd2;

  // Step actions.
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_TAKE   = 2'd1;
  localparam logic [1:0] ACT_DIV_GO = 2'd2;
  localparam logic [1:0] ACT_EMIT   = 2'd3;

  // Hold conditions: the step repeats until its condition is met.
  localparam logic [1:0] W_NONE  = 2'd0;
  localparam logic [1:0] W_THIRD = 2'd1;
  localparam logic [1:0] W_DIV   = 2'd2;
  localparam logic [1:0] W_OUT   = 2'd3;

  // Branch conditions, checked once the hold condition is met.
  localparam logic [1:0] BR_NEVER    = 2'd0;
  localparam logic [1:0] BR_ALWAYS   = 2'd1;
  localparam logic [1:0] BR_DET_ZERO = 2'd2;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_W-1:0] PC_EMIT = 5'd18;

  typedef struct packed {
    logic [1:0]      act;
    logic [2:0]      sel_a;
    logic [1:0]      sel_b;
    logic [1:0]      acc_op;
    logic [2:0]      acc_dst;
    logic [1:0]      wait_on;
    logic [1:0]      br;
    logic [PC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath: current control word and its hold status.
  typedef struct packed {
    uword_t w;
    logic   go;
  } ctrl_t;

  // Datapath and port status seen by the sequencer.
  typedef struct packed {
    logic third_in;
    logic div_idle;
    logic out_free;
    logic det_zero;
  } stat_t;

  // Saturating difference minuend - subtrahend on signed 32-bit values.
  function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] minuend,
                                            input logic [DW-1:0] subtrahend);
    logic [DW:0] d;
    d = {minuend[DW-1], minuend} - {subtrahend[DW-1], subtrahend};
    if (d[DW] != d[DW-1]) begin
      return d[DW] ? SAT_MIN : SAT_MAX;
    end
    return d[DW-1:0];
  endfunction

  function automatic uword_t mk(input logic [1:0] act, input logic [2:0] sel_a,
                                input logic [1:0] sel_b, input logic [1:0] acc_op,
                                input logic [2:0] acc_dst, input logic [1:0] wait_on,
                                input logic [1:0] br, input logic [PC_W-1:0] target);
    uword_t u;
    u.act     = act;
    u.sel_a   = sel_a;
    u.sel_b   = sel_b;
    u.acc_op  = acc_op;
    u.acc_dst = acc_dst;
    u.wait_on = wait_on;
    u.br      = br;
    u.target  = target;
    return u;
  endfunction

  // Microcode: determinant, six numerators, divide, emit.
  // A product started in one step is accumulated in the next.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t u;
    unique case (pc)
      5'd0:  u = mk(ACT_TAKE, A_DP1X, B_DU1, ACC_NONE, ACC_DET, W_THIRD, BR_NEVER, PC_IDLE);
      5'd1:  u = mk(ACT_NONE, A_DU1, B_DV2, ACC_NONE, ACC_DET, W_NONE, BR_NEVER, PC_IDLE);
      5'd2:  u = mk(ACT_NONE, A_DV1, B_DU2, ACC_LOAD, ACC_DET, W_NONE, BR_NEVER, PC_IDLE);
      5'd3:  u = mk(ACT_NONE, A_DP1X, B_DV2, ACC_SUB, ACC_DET, W_NONE, BR_NEVER, PC_IDLE);
      5'd4:  u = mk(ACT_NONE, A_DP2X, B_DV1, ACC_LOAD, ACC_T0, W_NONE, BR_DET_ZERO, PC_EMIT);
      5'd5:  u = mk(ACT_NONE, A_DP1Y, B_DV2, ACC_SUB, ACC_T0, W_NONE, BR_NEVER, PC_IDLE);
      5'd6:  u = mk(ACT_NONE, A_DP2Y, B_DV1, ACC_LOAD, ACC_T1, W_NONE, BR_NEVER, PC_IDLE);
      5'd7:  u = mk(ACT_NONE, A_DP1Z, B_DV2, ACC_SUB, ACC_T1, W_NONE, BR_NEVER, PC_IDLE);
      5'd8:  u = mk(ACT_NONE, A_DP2Z, B_DV1, ACC_LOAD, ACC_T2, W_NONE, BR_NEVER, PC_IDLE);
      5'd9:  u = mk(ACT_NONE, A_DP2X, B_DU1, ACC_SUB, ACC_T2, W_NONE, BR_NEVER, PC_IDLE);
      5'd10: u = mk(ACT_NONE, A_DP1X, B_DU2, ACC_LOAD, ACC_B0, W_NONE, BR_NEVER, PC_IDLE);
      5'd11: u = mk(ACT_NONE, A_DP2Y, B_DU1, ACC_SUB, ACC_B0, W_NONE, BR_NEVER, PC_IDLE);
      5'd12: u = mk(ACT_NONE, A_DP1Y, B_DU2, ACC_LOAD, ACC_B1, W_NONE, BR_NEVER, PC_IDLE);
      5'd13: u = mk(ACT_NONE, A_DP2Z, B_DU1, ACC_SUB, ACC_B1, W_NONE, BR_NEVER, PC_IDLE);
      5'd14: u = mk(ACT_NONE, A_DP1Z, B_DU2, ACC_LOAD, ACC_B2, W_NONE, BR_NEVER, PC_IDLE);
      5'd15: u = mk(ACT_NONE, A_DP1X, B_DU1, ACC_SUB, ACC_B2, W_NONE, BR_NEVER, PC_IDLE);
      5'd16: u = mk(ACT_DIV_GO, A_DP1X, B_DU1, ACC_NONE, ACC_DET, W_NONE, BR_NEVER,
                    PC_IDLE);
      5'd17: u = mk(ACT_NONE, A_DP1X, B_DU1, ACC_NONE, ACC_DET, W_DIV, BR_NEVER, PC_IDLE);
      5'd18: u = mk(ACT_EMIT, A_DP1X, B_DU1, ACC_NONE, ACC_DET, W_OUT, BR_ALWAYS, PC_IDLE);
      default: u = mk(ACT_NONE, A_DP1X, B_DU1, ACC_NONE, ACC_DET, W_NONE, BR_ALWAYS,
                      PC_IDLE);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/triangle_tangent_binormal_top.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_top
// Per-triangle tangent and binormal from corner positions and texture
// coordinates, signed fixed point.
// ----------------------------------------------------------------------------
// Corners stream in one request at a time; every third corner closes a
// triangle and yields one result request carrying the tangent and binormal,
// each saturated to signed Q16.16 (FRAC_BITS fraction bits), with tuser set
// and zero vectors when the UV determinant is zero. The first two corners of
// a triangle are taken and stored as they arrive. The closing corner starts a
// microcoded pass through a single 32x32 multiplier that builds the determinant
// and six numerators, followed by a six-lane divider that forms one quotient
// bit per cycle; a degenerate triangle skips the divider.
// The result sits in an output register, and the next corner is taken while it
// waits to be read; a stalled output holds the sequencer only when the
// following triangle is ready to be emitted.
// ----------------------------------------------------------------------------
`include "triangle_tangent_binormal_top_macros.svh"

module triangle_tangent_binormal_top import ttb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // position_x, position_y, position_z, texcoord_u, texcoord_v
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
  output logic [OUT_W-1:0] m_tdata,
  // degenerate
  output logic             m_tuser
);

  ctrl_t                ctrl;
  stat_t                stat;
  logic                 take;
  logic                 emit;
  logic                 div_start;
  logic                 out_free;
  logic                 third_in;
  logic                 det_zero;
  logic                 div_idle;
  logic signed [PW-1:0] num [NUM_LANES];
  logic signed [PW-1:0] den;
  logic [DW-1:0]        quo [NUM_LANES];

  // Handshake and step actions.
  assign s_tready  = (ctrl.w.act == ACT_TAKE);
  assign take      = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = ctrl.go && (ctrl.w.act == ACT_EMIT);
  assign div_start = ctrl.go && (ctrl.w.act == ACT_DIV_GO);

  assign stat.third_in = third_in;
  assign stat.div_idle = div_idle;
  assign stat.out_free = out_free;
  assign stat.det_zero = det_zero;

  ttb_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ttb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .take       (take),
    .position_x (s_tdata[DW-1:0]),
    .position_y (s_tdata[2*DW-1:DW]),
    .position_z (s_tdata[3*DW-1:2*DW]),
    .texcoord_u (s_tdata[4*DW-1:3*DW]),
    .texcoord_v (s_tdata[5*DW-1:4*DW]),
    .third_in   (third_in),
    .det_zero   (det_zero),
    .num        (num),
    .den        (den)
  );

  ttb_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .idle  (div_idle),
    .quo   (quo)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= det_zero;
      m_tdata <= det_zero ? '0 : {quo[5], quo[4], quo[3], quo[2], quo[1], quo[0]};
    end
  end

  `TTB_ASSERT_NOW(a_emit_free, clk, rst, emit, !m_tvalid || m_tready, "result overwrote a pending request")
  `TTB_ASSERT_NEXT(a_degen_zero, clk, rst, emit && det_zero, m_tuser && m_tdata == '0, "degenerate result not zero")
  `TTB_ASSERT_NOW(a_take_div_idle, clk, rst, s_tready, div_idle, "corner taken while divider busy")

endmodule

// ===== rtl/core/ttb_seq.sv =====
// ----------------------------------------------------------------------------
// ttb_seq
// Step counter and microcode table; holds a step until its condition is met
// and takes the step's branch when its branch condition holds.
// ----------------------------------------------------------------------------
module ttb_seq import ttb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          w;
  logic            go;
  logic            br_taken;

  assign w = ucode_rom(pc);

  // Hold condition of the current step.
  always_comb begin
    unique case (w.wait_on)
      W_NONE:  go = 1'b1;
      W_THIRD: go = stat.third_in;
      W_DIV:   go = stat.div_idle;
      W_OUT:   go = stat.out_free;
    endcase
  end

  // Branch condition of the current step.
  always_comb begin
    unique case (w.br)
      BR_NEVER:    br_taken = 1'b0;
      BR_ALWAYS:   br_taken = 1'b1;
      BR_DET_ZERO: br_taken = stat.det_zero;
      default:     br_taken = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    if (!go) begin
      pc_next = pc;
    end else if (br_taken) begin
      pc_next = w.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.w  = w;
  assign ctrl.go = go;

endmodule

// ===== rtl/core/ttb_datapath.sv =====
// ----------------------------------------------------------------------------
// ttb_datapath
// Corner storage, saturated edge deltas, the shared 32x32 multiplier and the
// accumulators that build the determinant and the six numerators.
// ----------------------------------------------------------------------------
module ttb_datapath import ttb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  input  logic                 take,
  input  logic [DW-1:0]        position_x,
  input  logic [DW-1:0]        position_y,
  input  logic [DW-1:0]        position_z,
  input  logic [DW-1:0]        texcoord_u,
  input  logic [DW-1:0]        texcoord_v,
  output logic                 third_in,
  output logic                 det_zero,
  output logic signed [PW-1:0] num [NUM_LANES],
  output logic signed [PW-1:0] den
);

  logic [1:0]           corner_count;
  logic [DW-1:0]        in_pos [3];
  logic [DW-1:0]        c0_pos [3];
  logic [DW-1:0]        c1_pos [3];
  logic [DW-1:0]        c0_uv  [2];
  logic [DW-1:0]        c1_uv  [2];
  logic signed [DW-1:0] a_file [A_DEPTH];
  logic signed [DW-1:0] b_file [B_DEPTH];
  logic signed [DW-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc [NUM_ACC];
  logic [DW-1:0]        du1;
  logic [DW-1:0]        dv1;
  logic [DW-1:0]        du2;
  logic [DW-1:0]        dv2;

  assign in_pos[0] = position_x;
  assign in_pos[1] = position_y;
  assign in_pos[2] = position_z;

  // A count of two (or the unused three) marks the closing corner.
  assign third_in = take && corner_count[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (take) begin
      unique case (corner_count)
        2'd0:    corner_count <= 2'd1;
        2'd1:    corner_count <= 2'd2;
        default: corner_count <= 2'd0;
      endcase
    end
  end

  // Keep the first two corners of the triangle.
  always_ff @(posedge clk) begin
    if (take && corner_count == 2'd0) begin
      c0_pos[0] <= position_x;
      c0_pos[1] <= position_y;
      c0_pos[2] <= position_z;
      c0_uv[0]  <= texcoord_u;
      c0_uv[1]  <= texcoord_v;
    end
    if (take && corner_count == 2'd1) begin
      c1_pos[0] <= position_x;
      c1_pos[1] <= position_y;
      c1_pos[2] <= position_z;
      c1_uv[0]  <= texcoord_u;
      c1_uv[1]  <= texcoord_v;
    end
  end

  // Saturated texture coordinate deltas against the first corner.
  assign du1 = sat_sub(c1_uv[0], c0_uv[0]);
  assign dv1 = sat_sub(c1_uv[1], c0_uv[1]);
  assign du2 = sat_sub(texcoord_u, c0_uv[0]);
  assign dv2 = sat_sub(texcoord_v, c0_uv[1]);

  // Operand files are loaded when the closing corner arrives.
  always_ff @(posedge clk) begin
    if (third_in) begin
      for (int i = 0; i < 3; i++) begin
        a_file[i]     <= sat_sub(c1_pos[i], c0_pos[i]);
        a_file[3 + i] <= sat_sub(in_pos[i], c0_pos[i]);
      end
      a_file[A_DU1] <= du1;
      a_file[A_DV1] <= dv1;
      b_file[B_DU1] <= du1;
      b_file[B_DV1] <= dv1;
      b_file[B_DU2] <= du2;
      b_file[B_DV2] <= dv2;
    end
  end

  // Shared multiplier with a registered product.
  assign op_a = a_file[ctrl.w.sel_a];
  assign op_b = b_file[ctrl.w.sel_b];

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Accumulate the product of the previous step.
  always_ff @(posedge clk) begin
    unique case (ctrl.w.acc_op)
      ACC_LOAD: acc[ctrl.w.acc_dst] <= prod;
      ACC_SUB:  acc[ctrl.w.acc_dst] <= acc[ctrl.w.acc_dst] - prod;
      default:  ;
    endcase
  end

  assign den      = acc[ACC_DET];
  assign det_zero = (acc[ACC_DET] == '0);
  assign num[0]   = acc[ACC_T0];
  assign num[1]   = acc[ACC_T1];
  assign num[2]   = acc[ACC_T2];
  assign num[3]   = acc[ACC_B0];
  assign num[4]   = acc[ACC_B1];
  assign num[5]   = acc[ACC_B2];

endmodule

// ===== rtl/core/ttb_div.sv =====
// ----------------------------------------------------------------------------
// ttb_div
// Six-lane restoring divider with a shared divisor: each lane forms
// (|num| * 2^FRAC_BITS) / |den| one quotient bit per cycle, then saturates the
// signed result to 32 bits.
// ----------------------------------------------------------------------------
`include "triangle_tangent_binormal_top_macros.svh"

module ttb_div import ttb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [PW-1:0] num [NUM_LANES],
  input  logic signed [PW-1:0] den,
  output logic                 idle,
  output logic [DW-1:0]        quo [NUM_LANES]
);

  localparam int NW    = PW + FRAC_BITS;
  localparam int CNT_W = $clog2(QBITS + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_ABS  = 2'd1;
  localparam logic [1:0] D_PREP = 2'd2;
  localparam logic [1:0] D_RUN  = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    ud;
  logic [PW-1:0]    mag [NUM_LANES];
  logic [PW-1:0]    rem [NUM_LANES];
  logic [QBITS-1:0] low [NUM_LANES];
  logic [QBITS-1:0] q   [NUM_LANES];
  logic             neg [NUM_LANES];
  logic             ovf [NUM_LANES];

  assign idle = (state == D_IDLE);

  // Sequence: magnitudes, overflow check, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_ABS;
          end
        end
        D_ABS: begin
          state <= D_PREP;
        end
        D_PREP: begin
          state <= D_RUN;
          cnt   <= CNT_W'(QBITS);
        end
        D_RUN: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= D_IDLE;
          end
        end
      endcase
    end
  end

  // Divisor magnitude, shared by all lanes.
  always_ff @(posedge clk) begin
    if (state == D_ABS) begin
      ud <= den[PW-1] ? PW'(-den) : PW'(den);
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [NW-1:0]    nwide;
    logic [PW-1:0]    rem_init;
    logic [PW:0]      trial;
    logic             trial_ge;
    logic [QBITS-1:0] mag_q;
    logic [DW-1:0]    neg_val;

    // Dividend is the numerator magnitude shifted up by the fraction bits.
    assign nwide    = {mag[l], {FRAC_BITS{1'b0}}};
    assign rem_init = PW'(nwide[NW-1:QBITS]);
    assign trial    = {rem[l], low[l][QBITS-1]};
    assign trial_ge = (trial >= {1'b0, ud});

    always_ff @(posedge clk) begin
      unique case (state)
        D_ABS: begin
          mag[l] <= num[l][PW-1] ? PW'(-num[l]) : PW'(num[l]);
          neg[l] <= num[l][PW-1] ^ den[PW-1];
        end
        D_PREP: begin
          // The quotient overflows 33 bits when the upper dividend reaches the divisor.
          ovf[l] <= (rem_init >= ud);
          rem[l] <= rem_init;
          low[l] <= nwide[QBITS-1:0];
          q[l]   <= '0;
        end
        D_RUN: begin
          rem[l] <= trial_ge ? PW'(trial - {1'b0, ud}) : trial[PW-1:0];
          q[l]   <= {q[l][QBITS-2:0], trial_ge};
          low[l] <= {low[l][QBITS-2:0], 1'b0};
        end
        default: ;
      endcase
    end

    // Signed saturation of the quotient magnitude.
    assign mag_q   = ovf[l] ? {1'b1, {DW{1'b0}}} : q[l];
    assign neg_val = ~mag_q[DW-1:0] + DW'(1);

    always_comb begin
      if (neg[l]) begin
        quo[l] = (mag_q > {1'b0, SAT_MIN}) ? SAT_MIN : neg_val;
      end else begin
        quo[l] = (mag_q > {1'b0, SAT_MAX}) ? SAT_MAX : mag_q[DW-1:0];
      end
    end
  end

  `TTB_ASSERT_NOW(a_start_idle, clk, rst, start, state == D_IDLE, "divider started while busy")
  `TTB_ASSERT_NOW(a_rem_bound, clk, rst, state == D_RUN && !ovf[0], rem[0] < ud, "remainder reached divisor")
  `TTB_ASSERT_NOW(a_leave_idle, clk, rst, $fell(idle), $past(start), "divider left idle without start")

endmodule
